// ----- rtl/core/ddiff_pkg.sv -----
// ----------------------------------------------------------------------------
// ddiff_pkg
// Shared types, constants and calendar tables for the date difference block,
// including the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddiff_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int QUOT_W  = 8;
    localparam int DIV_W   = YEAR_W - 2;
    localparam int PROD_W  = 25;
    localparam int RECIP_SHIFT = 17;

    localparam logic [YEAR_W-1:0]   MAX_YEAR = YEAR_W'(9999);
    localparam logic [PROD_W-1:0]   RECIP25  = PROD_W'(5243);
    localparam logic [COUNT_W-1:0]  DAYS_PER_YEAR = COUNT_W'(365);

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam int PC_W = 4;

    // input item, first field in the highest bits
    typedef struct packed {
        logic                include_end;
        logic [YEAR_W-1:0]   end_year;
        logic [MONTH_W-1:0]  end_month;
        logic [DAY_W-1:0]    end_day;
        logic [YEAR_W-1:0]   start_year;
        logic [MONTH_W-1:0]  start_month;
        logic [DAY_W-1:0]    start_day;
    } in_item_t;

    localparam int IN_ITEM_W = $bits(in_item_t);

    // datapath operations
    localparam logic [2:0] OP_DIVY   = 3'd0;
    localparam logic [2:0] OP_LEAP   = 3'd1;
    localparam logic [2:0] OP_CHK    = 3'd2;
    localparam logic [2:0] OP_SUB100 = 3'd3;
    localparam logic [2:0] OP_ADD400 = 3'd4;
    localparam logic [2:0] OP_SAVE   = 3'd5;
    localparam logic [2:0] OP_FIN    = 3'd6;

    // sequencer jump conditions
    localparam logic [1:0] J_NEXT = 2'd0;
    localparam logic [1:0] J_BAD  = 2'd1;
    localparam logic [1:0] J_END  = 2'd2;

    localparam logic SIDE_START = 1'b0;
    localparam logic SIDE_END   = 1'b1;

    localparam logic [PC_W-1:0] PC_FIN = PC_W'(11);

    typedef struct packed {
        logic            side;
        logic [2:0]      op;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    typedef struct packed {
        logic      start;
        logic      exec;
        ctl_word_t word;
    } ddiff_ctl_t;

    typedef struct packed {
        logic bad;
        logic out_busy;
    } ddiff_stat_t;

    function automatic ctl_word_t ucode_word(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        w = '{side: SIDE_START, op: OP_FIN, jmp: J_END, target: PC_FIN};
        case (pc)
            4'd0:  w = '{side: SIDE_START, op: OP_DIVY,   jmp: J_NEXT, target: PC_FIN};
            4'd1:  w = '{side: SIDE_START, op: OP_LEAP,   jmp: J_NEXT, target: PC_FIN};
            4'd2:  w = '{side: SIDE_START, op: OP_CHK,    jmp: J_NEXT, target: PC_FIN};
            4'd3:  w = '{side: SIDE_START, op: OP_SUB100, jmp: J_BAD,  target: PC_FIN};
            4'd4:  w = '{side: SIDE_START, op: OP_ADD400, jmp: J_NEXT, target: PC_FIN};
            4'd5:  w = '{side: SIDE_START, op: OP_SAVE,   jmp: J_NEXT, target: PC_FIN};
            4'd6:  w = '{side: SIDE_END,   op: OP_DIVY,   jmp: J_NEXT, target: PC_FIN};
            4'd7:  w = '{side: SIDE_END,   op: OP_LEAP,   jmp: J_NEXT, target: PC_FIN};
            4'd8:  w = '{side: SIDE_END,   op: OP_CHK,    jmp: J_NEXT, target: PC_FIN};
            4'd9:  w = '{side: SIDE_END,   op: OP_SUB100, jmp: J_BAD,  target: PC_FIN};
            4'd10: w = '{side: SIDE_END,   op: OP_ADD400, jmp: J_NEXT, target: PC_FIN};
            default: w = '{side: SIDE_START, op: OP_FIN, jmp: J_END, target: PC_FIN};
        endcase
        return w;
    endfunction

    // days in the year before the first of the month
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        if (m == 4'd2) begin
            r = leap ? DAY_W'(29) : DAY_W'(28);
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            r = DAY_W'(30);
        end else begin
            r = DAY_W'(31);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/date_difference_in_days.sv -----
// ----------------------------------------------------------------------------
// date_difference_in_days
// Number of days between two Gregorian dates, optionally counting the end day.
//
// The slave stream carries one query per transaction: start and end date and
// the include_end flag. The master stream returns the day count in tdata and
// a bad-date flag in tuser; a bad date gives a count of zero.
// A query runs through a microcoded sequence of twelve steps, one per cycle
// while the final step is not held by a stalled result: year division and
// leap test, date check and serial day number for each date, then the
// difference. When a date is bad, the sequence jumps from the step after its
// check to the final step. One query is worked on at a time: a new query is
// accepted only when the block is idle, after the last one has finished.
// s_tready is low while a query is in work. A finished result sits in the
// output register until taken; the next query is accepted meanwhile and its
// final step waits while the receiver stalls.
// Reset (aresetn low, synchronous) empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module date_difference_in_days (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year, include_end
    input  wire logic [ddiff_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // day_count
    output logic [ddiff_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // bad_date
    output logic                                     m_tuser
);
    import ddiff_pkg::*;

    logic               busy;
    ddiff_ctl_t         ctl;
    ddiff_stat_t        stat;
    in_item_t           in_item;
    logic [COUNT_W-1:0] out_count;

    assign in_item = s_tdata[IN_ITEM_W-1:0];

    ddiff_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .busy     (busy),
        .stat     (stat),
        .ctl      (ctl)
    );

    ddiff_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .in_item   (in_item),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (out_count),
        .out_bad   (m_tuser)
    );

    assign s_tready = !busy;
    assign m_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, out_count};

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad date with nonzero count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepting a query");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(busy))
        else $error("result raised without a query in work");

endmodule

`default_nettype wire

// ----- rtl/core/ddiff_urom.sv -----
// ----------------------------------------------------------------------------
// ddiff_urom
// Microcode store: one control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module ddiff_urom (
    input  wire logic [ddiff_pkg::PC_W-1:0] pc,
    output ddiff_pkg::ctl_word_t            word
);
    import ddiff_pkg::*;

    assign word = ucode_word(pc);

endmodule

`default_nettype wire

// ----- rtl/core/ddiff_seq.sv -----
// ----------------------------------------------------------------------------
// ddiff_seq
// Step counter with conditional jumps; fetches control words from the
// microcode store and hands them to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ddiff_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   busy,
    input  ddiff_pkg::ddiff_stat_t stat,
    output ddiff_pkg::ddiff_ctl_t  ctl
);
    import ddiff_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctl_word_t       word;
    logic            stall;
    logic            start;
    logic            exec;

    ddiff_urom u_urom (
        .pc   (pc_reg),
        .word (word)
    );

    // result step waits while the previous result is still held
    assign stall = (word.op == OP_FIN) && stat.out_busy;
    assign start = in_valid && !busy_reg;
    assign exec  = busy_reg && !stall;

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = '0;
        end else if (exec) begin
            case (word.jmp)
                J_END: begin
                    busy_next = 1'b0;
                    pc_next   = '0;
                end
                J_BAD: begin
                    pc_next = stat.bad ? word.target : pc_reg + PC_W'(1);
                end
                default: begin
                    pc_next = pc_reg + PC_W'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy       = busy_reg;
    assign ctl.start  = start;
    assign ctl.exec   = exec;
    assign ctl.word   = word;

endmodule

`default_nettype wire

// ----- rtl/core/ddiff_datapath.sv -----
// ----------------------------------------------------------------------------
// ddiff_datapath
// Accumulator datapath: serial day numbers by year and month arithmetic,
// date checks, and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ddiff_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  ddiff_pkg::ddiff_ctl_t                   ctl,
    input  ddiff_pkg::in_item_t                     in_item,
    output ddiff_pkg::ddiff_stat_t                  stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [ddiff_pkg::COUNT_W-1:0]           out_count,
    output logic                                    out_bad
);
    import ddiff_pkg::*;

    in_item_t            item_reg;
    logic [YEAR_W-1:0]   p_reg, p_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic                leap_reg, leap_next;
    logic                bad_reg, bad_next;
    logic [COUNT_W-1:0]  acc_reg, acc_next;
    logic [COUNT_W-1:0]  sa_reg, sa_next;
    logic                vld_reg, vld_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                flag_reg, flag_next;

    logic [DAY_W-1:0]    d_sel;
    logic [MONTH_W-1:0]  m_sel;
    logic [YEAR_W-1:0]   y_sel;
    logic [DIV_W-1:0]    div_in;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic [DIV_W-1:0]    q_x25;
    logic                date_ok;
    logic [COUNT_W-1:0]  diff;

    assign d_sel = (ctl.word.side == SIDE_END) ? item_reg.end_day   : item_reg.start_day;
    assign m_sel = (ctl.word.side == SIDE_END) ? item_reg.end_month : item_reg.start_month;
    assign y_sel = (ctl.word.side == SIDE_END) ? item_reg.end_year  : item_reg.start_year;

    // divide by 25 through a reciprocal multiply
    always_comb begin
        case (ctl.word.op)
            OP_DIVY: div_in = y_sel[YEAR_W-1:2];
            OP_CHK:  div_in = p_reg[YEAR_W-1:2];
            default: div_in = {2'b00, p_reg[YEAR_W-1:4]};
        endcase
    end

    assign prod = {{(PROD_W-DIV_W){1'b0}}, div_in} * RECIP25;
    assign quot = prod[RECIP_SHIFT +: QUOT_W];

    assign q_x25 = ({{(DIV_W-QUOT_W){1'b0}}, q_reg} << 4)
                 + ({{(DIV_W-QUOT_W){1'b0}}, q_reg} << 3)
                 +  {{(DIV_W-QUOT_W){1'b0}}, q_reg};

    assign date_ok = (y_sel != '0) && (y_sel <= MAX_YEAR)
                   && (m_sel != '0) && (m_sel <= MONTH_W'(12))
                   && (d_sel != '0) && (d_sel <= month_length(m_sel, leap_reg));

    assign diff = (sa_reg < acc_reg) ? acc_reg - sa_reg : '0;

    always_comb begin
        p_next    = p_reg;
        q_next    = q_reg;
        leap_next = leap_reg;
        bad_next  = bad_reg;
        acc_next  = acc_reg;
        sa_next   = sa_reg;
        vld_next  = vld_reg;
        cnt_next  = cnt_reg;
        flag_next = flag_reg;

        if (out_ready) begin
            vld_next = 1'b0;
        end

        if (ctl.start) begin
            bad_next = 1'b0;
        end else if (ctl.exec) begin
            case (ctl.word.op)
                OP_DIVY: begin
                    q_next = quot;
                    p_next = y_sel - YEAR_W'(1);
                end
                OP_LEAP: begin
                    leap_next = (y_sel[1:0] == 2'b00)
                              && ((y_sel[YEAR_W-1:2] != q_x25) || (q_reg[1:0] == 2'b00));
                    acc_next  = {{(COUNT_W-DAY_W){1'b0}}, d_sel}
                              + {{(COUNT_W-9){1'b0}}, days_before_month(m_sel)};
                end
                OP_CHK: begin
                    bad_next = bad_reg || !date_ok;
                    acc_next = acc_reg
                             + {{(COUNT_W-YEAR_W){1'b0}}, p_reg} * DAYS_PER_YEAR;
                    q_next   = quot;
                end
                OP_SUB100: begin
                    acc_next = acc_reg - {{(COUNT_W-QUOT_W){1'b0}}, q_reg}
                             + {{(COUNT_W-DIV_W){1'b0}}, p_reg[YEAR_W-1:2]};
                    q_next   = quot;
                end
                OP_ADD400: begin
                    acc_next = acc_reg + {{(COUNT_W-QUOT_W){1'b0}}, q_reg}
                             + {{(COUNT_W-1){1'b0}},
                                ((m_sel > MONTH_W'(2)) && leap_reg)};
                end
                OP_SAVE: begin
                    sa_next = acc_reg;
                end
                OP_FIN: begin
                    vld_next = 1'b1;
                    if (bad_reg) begin
                        cnt_next  = '0;
                        flag_next = 1'b1;
                    end else begin
                        cnt_next  = diff + {{(COUNT_W-1){1'b0}}, item_reg.include_end};
                        flag_next = 1'b0;
                    end
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            bad_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            item_reg <= in_item;
        end
        p_reg    <= p_next;
        q_reg    <= q_next;
        leap_reg <= leap_next;
        acc_reg  <= acc_next;
        sa_reg   <= sa_next;
        cnt_reg  <= cnt_next;
        flag_reg <= flag_next;
    end

    assign stat.bad      = bad_reg;
    assign stat.out_busy = vld_reg && !out_ready;

    assign out_valid = vld_reg;
    assign out_count = cnt_reg;
    assign out_bad   = flag_reg;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for date_difference_in_days.
//
// Queries go in on the slave stream. The sender works in bursts with random
// gaps, and it waits at times until every result has come back. The receiver
// stalls in a pattern set by cycle counter bits 9:8. A directed table covers
// the calendar extremes, leap-year rules and every kind of bad date. After
// it come random queries: mostly valid dates with their content biased toward
// month ends and century years, plus some raw noise and some corrupted days.
// Each result is checked in order against the table or a calendar predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ddiff_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               bad;
    } span_t;

    typedef struct {
        in_item_t query;
        bit       known;
        span_t    span;
    } dir_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_SPARSE,
        RDY_STALL
    } rdy_mode_e;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tuser;

    span_t       span_q [$];
    dir_row_t    directed_q [$];
    span_t       want;
    int unsigned err_cnt    = 0;
    int unsigned cycle_cnt  = 0;
    int          burst_left = 0;

    date_difference_in_days dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // calendar predictor

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        return (y >= 1) && (y <= 32'(MAX_YEAR)) && (m >= 1) && (m <= 12)
            && (d >= 1) && (d <= month_days(m, y));
    endfunction

    // 0001-01-01 is day 1
    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++) begin
            n += month_days(k, y);
        end
        return n + d;
    endfunction

    function automatic span_t predict_span(input in_item_t q);
        span_t       r;
        int unsigned a;
        int unsigned b;
        int unsigned n;
        int unsigned sd, sm, sy, ed, em, ey;
        sd = 32'(q.start_day);
        sm = 32'(q.start_month);
        sy = 32'(q.start_year);
        ed = 32'(q.end_day);
        em = 32'(q.end_month);
        ey = 32'(q.end_year);
        r.count = '0;
        r.bad   = 1'b0;
        if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
            r.bad = 1'b1;
            return r;
        end
        a = day_number(sd, sm, sy);
        b = day_number(ed, em, ey);
        n = (a < b) ? b - a : 0;
        r.count = COUNT_W'(n + 32'(q.include_end));
        return r;
    endfunction

    // stimulus

    function automatic dir_row_t make_row(input int sd, input int sm, input int sy,
                                          input int ed, input int em, input int ey,
                                          input int inc, input bit known,
                                          input int unsigned cnt, input bit bad);
        dir_row_t r;
        r.query.start_day   = DAY_W'(sd);
        r.query.start_month = MONTH_W'(sm);
        r.query.start_year  = YEAR_W'(sy);
        r.query.end_day     = DAY_W'(ed);
        r.query.end_month   = MONTH_W'(em);
        r.query.end_year    = YEAR_W'(ey);
        r.query.include_end = inc[0];
        r.known             = known;
        r.span.count        = COUNT_W'(cnt);
        r.span.bad          = bad;
        return r;
    endfunction

    function automatic int unsigned pick_year();
        int unsigned y;
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(1, 9999);
            1:       y = 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
            2:       y = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(9995, 9999);
            default: y = 4 * $urandom_range(1, 2499);
        endcase
        return y;
    endfunction

    function automatic void pick_md(input int unsigned y, output int unsigned d,
                                    output int unsigned m);
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 3) == 0) ? month_days(m, y) : $urandom_range(1, month_days(m, y));
    endfunction

    function automatic in_item_t random_query();
        in_item_t    q;
        int unsigned sel;
        int unsigned sd, sm, sy, ed, em, ey;
        sel = $urandom_range(0, 99);
        q.include_end = 1'($urandom_range(0, 1));
        if (sel < 12) begin
            // raw noise over the whole field ranges
            q.start_day   = DAY_W'($urandom_range(0, 31));
            q.start_month = MONTH_W'($urandom_range(0, 15));
            q.start_year  = YEAR_W'($urandom_range(0, 16383));
            q.end_day     = DAY_W'($urandom_range(0, 31));
            q.end_month   = MONTH_W'($urandom_range(0, 15));
            q.end_year    = YEAR_W'($urandom_range(0, 16383));
            return q;
        end
        sy = pick_year();
        pick_md(sy, sd, sm);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                ey = pick_year();
                pick_md(ey, ed, em);
            end
            4, 5, 6, 7, 8: begin
                ey = sy + $urandom_range(0, 1);
                if (ey > 32'(MAX_YEAR)) ey = 32'(MAX_YEAR);
                pick_md(ey, ed, em);
            end
            default: begin
                ed = sd;
                em = sm;
                ey = sy;
            end
        endcase
        // day just past month end or day zero
        if (sel < 20) begin
            if ($urandom_range(0, 1)) sd = $urandom_range(0, 1) ? month_days(sm, sy) + 1 : 0;
            else ed = $urandom_range(0, 1) ? month_days(em, ey) + 1 : 0;
        end
        q.start_day   = DAY_W'(sd);
        q.start_month = MONTH_W'(sm);
        q.start_year  = YEAR_W'(sy);
        q.end_day     = DAY_W'(ed);
        q.end_month   = MONTH_W'(em);
        q.end_year    = YEAR_W'(ey);
        return q;
    endfunction

    task automatic send_query(input in_item_t q, input span_t s);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(q);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        span_q.push_back(s);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        span_t    s;
        in_item_t q;
        directed_q.push_back(make_row(1, 1, 1, 1, 1, 1, 0, 1, 0, 0));
        directed_q.push_back(make_row(1, 1, 1, 1, 1, 1, 1, 1, 1, 0));
        directed_q.push_back(make_row(1, 1, 1, 2, 1, 1, 0, 1, 1, 0));
        directed_q.push_back(make_row(1, 1, 1, 31, 12, 9999, 1, 0, 0, 0));
        directed_q.push_back(make_row(31, 12, 9999, 1, 1, 1, 0, 1, 0, 0));
        directed_q.push_back(make_row(31, 12, 9999, 1, 1, 1, 1, 1, 1, 0));
        directed_q.push_back(make_row(28, 2, 2023, 1, 3, 2023, 0, 1, 1, 0));
        directed_q.push_back(make_row(28, 2, 2024, 1, 3, 2024, 0, 1, 2, 0));
        directed_q.push_back(make_row(29, 2, 2000, 1, 3, 2000, 0, 1, 1, 0));
        directed_q.push_back(make_row(31, 12, 1999, 1, 1, 2000, 0, 1, 1, 0));
        directed_q.push_back(make_row(29, 2, 1900, 1, 3, 1900, 0, 1, 0, 1));
        directed_q.push_back(make_row(1, 1, 2020, 30, 2, 2024, 1, 1, 0, 1));
        directed_q.push_back(make_row(31, 4, 2020, 1, 5, 2020, 0, 1, 0, 1));
        directed_q.push_back(make_row(0, 1, 2020, 1, 5, 2020, 1, 1, 0, 1));
        directed_q.push_back(make_row(1, 1, 2020, 0, 5, 2020, 0, 1, 0, 1));
        directed_q.push_back(make_row(1, 0, 2020, 1, 5, 2020, 1, 1, 0, 1));
        directed_q.push_back(make_row(1, 13, 2020, 1, 5, 2020, 0, 1, 0, 1));
        directed_q.push_back(make_row(1, 1, 2020, 1, 15, 2020, 1, 1, 0, 1));
        directed_q.push_back(make_row(1, 1, 0, 1, 5, 2020, 0, 1, 0, 1));
        directed_q.push_back(make_row(1, 1, 2020, 1, 1, 10000, 1, 1, 0, 1));
        directed_q.push_back(make_row(31, 15, 16383, 31, 15, 16383, 1, 1, 0, 1));
        directed_q.push_back(make_row(1, 3, 1600, 1, 3, 2000, 0, 0, 0, 0));
        directed_q.push_back(make_row(15, 6, 1999, 14, 6, 2000, 1, 0, 0, 0));
        directed_q.push_back(make_row(1, 1, 2001, 31, 12, 9999, 0, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[i]) begin
            s = directed_q[i].known ? directed_q[i].span : predict_span(directed_q[i].query);
            send_query(directed_q[i].query, s);
        end
        wait_idle();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            q = random_query();
            send_query(q, predict_span(q));
            if (i == RANDOM_ITEMS / 2) wait_idle();
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        case (rdy_mode_e'(cycle_cnt[9:8]))
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_tready <= (cycle_cnt[2:0] == 3'd0);
            default:    m_tready <= (cycle_cnt[5:0] >= 6'd40);
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (span_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transaction, expected none, actual count %0d bad %0b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = span_q.pop_front();
                if (m_tdata !== OUT_TDATA_W'(want.count)) begin
                    err_cnt++;
                    $display("%0t: day_count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_tdata);
                end
                if (m_tuser !== want.bad) begin
                    err_cnt++;
                    $display("%0t: bad_date mismatch, expected %0b, actual %0b",
                             $time, want.bad, m_tuser);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/ddiff_pkg.sv
rtl/core/ddiff_urom.sv
rtl/core/ddiff_seq.sv
rtl/core/ddiff_datapath.sv
rtl/core/date_difference_in_days.sv
test/tb_top.sv
